[hdl/tie_pkg.sv]
// ----------------------------------------------------------------------------
// tie_pkg
// Shared types and constants for the Thumb instruction executor.
// ----------------------------------------------------------------------------
package tie_pkg;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_UNDEF  = 3'd1;
   localparam logic [2:0] ST_SWI    = 3'd2;
   localparam logic [2:0] ST_BKPT   = 3'd3;
   localparam logic [2:0] ST_UNSUP  = 3'd4;
   localparam logic [2:0] ST_ARM    = 3'd5;
   localparam logic [2:0] ST_HALTED = 3'd6;

   localparam logic [1:0] EXC_NONE  = 2'd0;
   localparam logic [1:0] EXC_UNDEF = 2'd1;
   localparam logic [1:0] EXC_SWI   = 2'd2;

   // instruction formats, selected by bits 15:11
   localparam logic [4:0] FMT_LSL    = 5'd0;
   localparam logic [4:0] FMT_LSR    = 5'd1;
   localparam logic [4:0] FMT_ASR    = 5'd2;
   localparam logic [4:0] FMT_ADDSUB = 5'd3;
   localparam logic [4:0] FMT_MOVI   = 5'd4;
   localparam logic [4:0] FMT_CMPI   = 5'd5;
   localparam logic [4:0] FMT_ADDI   = 5'd6;
   localparam logic [4:0] FMT_SUBI   = 5'd7;
   localparam logic [4:0] FMT_DP     = 5'd8;
   localparam logic [4:0] FMT_ADR    = 5'd20;
   localparam logic [4:0] FMT_ADDSP  = 5'd21;
   localparam logic [4:0] FMT_MISC0  = 5'd22;
   localparam logic [4:0] FMT_MISC1  = 5'd23;
   localparam logic [4:0] FMT_BCC0   = 5'd26;
   localparam logic [4:0] FMT_BCC1   = 5'd27;
   localparam logic [4:0] FMT_B      = 5'd28;

   // register ALU operations, bits 9:6
   localparam logic [3:0] ALU_AND = 4'd0;
   localparam logic [3:0] ALU_EOR = 4'd1;
   localparam logic [3:0] ALU_LSL = 4'd2;
   localparam logic [3:0] ALU_LSR = 4'd3;
   localparam logic [3:0] ALU_ASR = 4'd4;
   localparam logic [3:0] ALU_ADC = 4'd5;
   localparam logic [3:0] ALU_SBC = 4'd6;
   localparam logic [3:0] ALU_ROR = 4'd7;
   localparam logic [3:0] ALU_TST = 4'd8;
   localparam logic [3:0] ALU_NEG = 4'd9;
   localparam logic [3:0] ALU_CMP = 4'd10;
   localparam logic [3:0] ALU_CMN = 4'd11;
   localparam logic [3:0] ALU_ORR = 4'd12;
   localparam logic [3:0] ALU_MUL = 4'd13;
   localparam logic [3:0] ALU_BIC = 4'd14;
   localparam logic [3:0] ALU_MVN = 4'd15;

   // high-register operations, bits 9:8
   localparam logic [1:0] HI_ADD = 2'd0;
   localparam logic [1:0] HI_CMP = 2'd1;
   localparam logic [1:0] HI_MOV = 2'd2;
   localparam logic [1:0] HI_BX  = 2'd3;

   // condition field values that are not branch conditions
   localparam logic [3:0] COND_UNDEF = 4'd14;
   localparam logic [3:0] COND_SWI   = 4'd15;

   // register numbers with a fixed role
   localparam logic [3:0] REG_SP = 4'd13;
   localparam logic [3:0] REG_PC = 4'd15;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        dest_written;
      logic [3:0]  dest_index;
      logic [31:0] dest_value;
      logic [3:0]  flags_out;
      logic [2:0]  status;
   } rsp_type;

endpackage

[hdl/tie_if.sv]
// ----------------------------------------------------------------------------
// tie_req_if / tie_rsp_if
// Valid/ready channels carrying instructions and results.
// ----------------------------------------------------------------------------
interface tie_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] instruction;
   modport source (output valid, output instruction, input ready);
   modport sink   (input valid, input instruction, output ready);
endinterface

interface tie_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic        dest_written;
   logic [3:0]  dest_index;
   logic [31:0] dest_value;
   logic [3:0]  flags_out;
   logic [2:0]  status;
   modport source (output valid, output next_pc, output dest_written, output dest_index,
                   output dest_value, output flags_out, output status, input ready);
   modport sink   (input valid, input next_pc, input dest_written, input dest_index,
                   input dest_value, input flags_out, input status, output ready);
endinterface

[hdl/tie_regfile.sv]
// ----------------------------------------------------------------------------
// tie_regfile
// Sixteen-entry register memory, two registered read ports, one write port.
// Entries not yet written since reset read as zero via valid bits.
// ----------------------------------------------------------------------------
module tie_regfile (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [3:0]  rd_addr_a,
   input  logic [3:0]  rd_addr_b,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b,
   input  logic        wr_en,
   input  logic [3:0]  wr_addr,
   input  logic [31:0] wr_data
);
   logic [31:0] mem [16];
   logic [15:0] vld_ff;
   logic [31:0] qa_ff, qb_ff;
   logic        va_ff, vb_ff;

   // memory write; reads held until the next item is taken
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) begin
         qa_ff <= mem[rd_addr_a];
         qb_ff <= mem[rd_addr_b];
      end
   end

   // valid bits stand in for a clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         va_ff  <= 1'b0;
         vb_ff  <= 1'b0;
      end else begin
         if (wr_en) vld_ff[wr_addr] <= 1'b1;
         if (rd_en) begin
            va_ff <= vld_ff[rd_addr_a];
            vb_ff <= vld_ff[rd_addr_b];
         end
      end
   end

   assign rd_data_a = va_ff ? qa_ff : 32'd0;
   assign rd_data_b = vb_ff ? qb_ff : 32'd0;
endmodule

[hdl/tie_execute.sv]
// ----------------------------------------------------------------------------
// tie_execute
// Combinational execute of one instruction from read operands and state.
// ----------------------------------------------------------------------------
module tie_execute (
   input  logic [15:0]     op,
   input  logic [31:0]     ra,        // register selected by port a
   input  logic [31:0]     rb,        // register selected by port b
   input  logic [31:0]     pc,
   input  logic [3:0]      flags,
   input  logic [1:0]      exc,
   input  logic            halted,
   input  logic            arm,
   output tie_pkg::rsp_type res,
   output logic [1:0]      exc_in,
   output logic            halted_in,
   output logic            arm_in,
   output logic [31:0]     mul_a,
   output logic [31:0]     mul_b,
   input  logic [31:0]     mul_p
);
   logic [31:0] pcv, r, a, b, t, x;
   logic [32:0] s;
   logic        nf, zf, cf, vf, cin;
   logic [4:0]  top;
   logic [2:0]  d8;
   logic [3:0]  rd;
   logic [6:0]  k;
   logic [7:0]  sa;
   logic        do_add, setnz, wr;
   logic        ccok;

   // operand selection for the register multiply
   assign mul_a = ra;
   assign mul_b = rb;

   always_comb begin
      pcv = pc + 32'd4;
      top = op[15:11];
      d8  = op[10:8];
      k   = op[11:5];
      rd  = {op[7], op[2:0]};
      nf = flags[3]; zf = flags[2]; cf = flags[1]; vf = flags[0];
      a = 32'd0; b = 32'd0; cin = 1'b0; do_add = 1'b0; setnz = 1'b0;
      r = 32'd0; wr = 1'b0; t = 32'd0; x = rb; s = 33'd0; sa = 8'd0; ccok = 1'b0;
      res = '0;
      res.next_pc = pc;
      exc_in = exc; halted_in = halted; arm_in = arm;
      if (halted) res.status = tie_pkg::ST_HALTED;
      else if (arm) res.status = tie_pkg::ST_ARM;
      else if (exc != tie_pkg::EXC_NONE) begin
         halted_in = 1'b1;
         res.status = tie_pkg::ST_HALTED;
      end else begin
         res.next_pc = pc + 32'd2;
         res.dest_index = {1'b0, op[2:0]};
         case (top)
            tie_pkg::FMT_LSL: begin
               sa = {3'd0, op[10:6]};
               r = rb << sa[4:0];
               if (sa != 8'd0) cf = rb[5'd0 - sa[4:0]];
               setnz = 1'b1; wr = 1'b1;
            end
            tie_pkg::FMT_LSR, tie_pkg::FMT_ASR: begin
               sa = (op[10:6] == 5'd0) ? 8'd32 : {3'd0, op[10:6]};
               if (sa == 8'd32) begin
                  cf = rb[31];
                  r = (top == tie_pkg::FMT_ASR && rb[31]) ? 32'hFFFFFFFF : 32'd0;
               end else begin
                  cf = rb[sa[4:0] - 5'd1];
                  r = (top == tie_pkg::FMT_ASR) ? 32'($signed(rb) >>> sa[4:0])
                                                : rb >> sa[4:0];
               end
               setnz = 1'b1; wr = 1'b1;
            end
            tie_pkg::FMT_ADDSUB: begin
               a = rb;
               b = op[10] ? {29'd0, op[8:6]} : ra;
               if (op[9]) begin b = ~b; cin = 1'b1; end
               do_add = 1'b1; wr = 1'b1;
            end
            tie_pkg::FMT_MOVI: begin
               r = {24'd0, op[7:0]}; setnz = 1'b1; wr = 1'b1;
               res.dest_index = {1'b0, d8};
            end
            tie_pkg::FMT_CMPI: begin
               a = ra; b = ~{24'd0, op[7:0]}; cin = 1'b1; do_add = 1'b1;
            end
            tie_pkg::FMT_ADDI, tie_pkg::FMT_SUBI: begin
               a = ra; b = {24'd0, op[7:0]};
               if (top == tie_pkg::FMT_SUBI) begin b = ~b; cin = 1'b1; end
               do_add = 1'b1; wr = 1'b1; res.dest_index = {1'b0, d8};
            end
            tie_pkg::FMT_DP: begin
               if (!op[10]) begin
                  // register ALU: ra = rd, rb = rm
                  a = ra; sa = rb[7:0];
                  case (op[9:6])
                     tie_pkg::ALU_AND: begin r = ra & rb; setnz = 1'b1; wr = 1'b1; end
                     tie_pkg::ALU_EOR: begin r = ra ^ rb; setnz = 1'b1; wr = 1'b1; end
                     tie_pkg::ALU_LSL: begin
                        if (sa == 8'd0) r = ra;
                        else if (sa < 8'd32) begin
                           cf = ra[5'd0 - sa[4:0]]; r = ra << sa[4:0];
                        end else begin cf = (sa == 8'd32) ? ra[0] : 1'b0; r = 32'd0; end
                        setnz = 1'b1; wr = 1'b1;
                     end
                     tie_pkg::ALU_LSR: begin
                        if (sa == 8'd0) r = ra;
                        else if (sa < 8'd32) begin
                           cf = ra[sa[4:0] - 5'd1]; r = ra >> sa[4:0];
                        end else begin cf = (sa == 8'd32) ? ra[31] : 1'b0; r = 32'd0; end
                        setnz = 1'b1; wr = 1'b1;
                     end
                     tie_pkg::ALU_ASR: begin
                        if (sa == 8'd0) r = ra;
                        else if (sa < 8'd32) begin
                           cf = ra[sa[4:0] - 5'd1]; r = 32'($signed(ra) >>> sa[4:0]);
                        end else begin cf = ra[31]; r = {32{ra[31]}}; end
                        setnz = 1'b1; wr = 1'b1;
                     end
                     tie_pkg::ALU_ADC: begin b = rb; cin = cf; do_add = 1'b1; wr = 1'b1; end
                     tie_pkg::ALU_SBC: begin b = ~rb; cin = cf; do_add = 1'b1; wr = 1'b1; end
                     tie_pkg::ALU_ROR: begin
                        if (sa == 8'd0) r = ra;
                        else begin
                           r = (ra >> sa[4:0]) | (ra << (6'd32 - {1'b0, sa[4:0]}));
                           if (sa[4:0] == 5'd0) r = ra;
                           cf = r[31];
                        end
                        setnz = 1'b1; wr = 1'b1;
                     end
                     tie_pkg::ALU_TST: begin r = ra & rb; setnz = 1'b1; end
                     tie_pkg::ALU_NEG: begin
                        a = 32'd0; b = ~rb; cin = 1'b1; do_add = 1'b1; wr = 1'b1;
                     end
                     tie_pkg::ALU_CMP: begin b = ~rb; cin = 1'b1; do_add = 1'b1; end
                     tie_pkg::ALU_CMN: begin b = rb; do_add = 1'b1; end
                     tie_pkg::ALU_ORR: begin r = ra | rb; setnz = 1'b1; wr = 1'b1; end
                     tie_pkg::ALU_MUL: begin r = mul_p; setnz = 1'b1; wr = 1'b1; end
                     tie_pkg::ALU_BIC: begin r = ra & ~rb; setnz = 1'b1; wr = 1'b1; end
                     default: begin r = ~rb; setnz = 1'b1; wr = 1'b1; end
                  endcase
               end else begin
                  // high registers: ra = rd, rb = rm (r15 fixed up by caller)
                  if (op[9:8] == tie_pkg::HI_BX) begin
                     if (op[7]) res.status = tie_pkg::ST_UNSUP;
                     else begin
                        res.next_pc = {rb[31:1], 1'b0};
                        if (!rb[0]) begin arm_in = 1'b1; res.status = tie_pkg::ST_ARM; end
                     end
                  end else if (op[7:6] == 2'd0) begin
                     exc_in = tie_pkg::EXC_UNDEF; res.status = tie_pkg::ST_UNDEF;
                  end else begin
                     res.dest_index = rd;
                     case (op[9:8])
                        tie_pkg::HI_ADD: begin r = ra + rb; wr = 1'b1; end
                        tie_pkg::HI_CMP: begin
                           a = ra; b = ~rb; cin = 1'b1; do_add = 1'b1;
                        end
                        default: begin r = rb; wr = 1'b1; end
                     endcase
                  end
               end
            end
            tie_pkg::FMT_ADR: begin
               r = {pcv[31:2], 2'd0} + {22'd0, op[7:0], 2'd0}; wr = 1'b1;
               res.dest_index = {1'b0, d8};
            end
            tie_pkg::FMT_ADDSP: begin
               r = ra + {22'd0, op[7:0], 2'd0}; wr = 1'b1;
               res.dest_index = {1'b0, d8};
            end
            tie_pkg::FMT_MISC0, tie_pkg::FMT_MISC1: begin
               // misc: ra = r13, rb = low register at op[5:3]
               x = rb;
               if (k <= 7'h03) begin
                  r = ra + {23'd0, op[6:0], 2'd0}; wr = 1'b1;
                  res.dest_index = tie_pkg::REG_SP;
               end else if (k <= 7'h07) begin
                  r = ra - {23'd0, op[6:0], 2'd0}; wr = 1'b1;
                  res.dest_index = tie_pkg::REG_SP;
               end else if (k == 7'h10 || k == 7'h11) begin
                  r = {{16{x[15]}}, x[15:0]}; wr = 1'b1;
               end else if (k == 7'h12 || k == 7'h13) begin
                  r = {{24{x[7]}}, x[7:0]}; wr = 1'b1;
               end else if (k == 7'h14 || k == 7'h15) begin
                  r = {16'd0, x[15:0]}; wr = 1'b1;
               end else if (k == 7'h16 || k == 7'h17) begin
                  r = {24'd0, x[7:0]}; wr = 1'b1;
               end else if (k == 7'h50 || k == 7'h51) begin
                  r = {x[7:0], x[15:8], x[23:16], x[31:24]}; wr = 1'b1;
               end else if (k == 7'h52 || k == 7'h53) begin
                  r = {x[23:16], x[31:24], x[7:0], x[15:8]}; wr = 1'b1;
               end else if (k == 7'h56 || k == 7'h57) begin
                  r = {{16{x[7]}}, x[7:0], x[15:8]}; wr = 1'b1;
               end else if ((k >= 7'h20 && k <= 7'h2F) || k == 7'h33 ||
                            (k >= 7'h60 && k <= 7'h6F) || k >= 7'h78) begin
                  res.status = tie_pkg::ST_UNSUP;
               end else if (k >= 7'h70) begin
                  halted_in = 1'b1; res.status = tie_pkg::ST_BKPT;
               end else begin
                  exc_in = tie_pkg::EXC_UNDEF; res.status = tie_pkg::ST_UNDEF;
               end
            end
            tie_pkg::FMT_BCC0, tie_pkg::FMT_BCC1: begin
               case (op[11:8])
                  4'd0:  ccok = zf;
                  4'd1:  ccok = !zf;
                  4'd2:  ccok = cf;
                  4'd3:  ccok = !cf;
                  4'd4:  ccok = nf;
                  4'd5:  ccok = !nf;
                  4'd6:  ccok = vf;
                  4'd7:  ccok = !vf;
                  4'd8:  ccok = cf && !zf;
                  4'd9:  ccok = !cf || zf;
                  4'd10: ccok = nf == vf;
                  4'd11: ccok = nf != vf;
                  4'd12: ccok = !zf && nf == vf;
                  default: ccok = zf || nf != vf;
               endcase
               if (op[11:8] == tie_pkg::COND_UNDEF) begin
                  exc_in = tie_pkg::EXC_UNDEF; res.status = tie_pkg::ST_UNDEF;
               end else if (op[11:8] == tie_pkg::COND_SWI) begin
                  exc_in = tie_pkg::EXC_SWI; res.status = tie_pkg::ST_SWI;
               end else if (ccok) begin
                  res.next_pc = pcv + {{23{op[7]}}, op[7:0], 1'b0};
               end
            end
            tie_pkg::FMT_B: res.next_pc = pcv + {{20{op[10]}}, op[10:0], 1'b0};
            default: res.status = tie_pkg::ST_UNSUP;
         endcase
         // shared adder with ARM flag rules
         if (do_add) begin
            s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
            r = s[31:0];
            cf = s[32];
            vf = (a[31] ^ r[31]) & (b[31] ^ r[31]);
            setnz = 1'b1;
         end
         if (setnz) begin nf = r[31]; zf = (r == 32'd0); end
         if (wr) begin
            res.dest_written = 1'b1;
            if (res.dest_index == tie_pkg::REG_PC) begin
               t = {r[31:1], 1'b0};
               res.next_pc = t;
               res.dest_value = t;
            end else res.dest_value = r;
         end else res.dest_index = 4'd0;
      end
      res.flags_out = {nf, zf, cf, vf};
   end
endmodule

[hdl/thumb_instruction_executor.sv]
// ----------------------------------------------------------------------------
// thumb_instruction_executor
// The register memory reads an accepted item's operands; execute and write-back follow
// once the result slot is free. A new item is taken only after the current one has executed.
// The result register lets the next item enter while a result waits.
// Synchronous reset clears pc, flags, exception, halt, ARM state and register valid bits.
// ----------------------------------------------------------------------------
module thumb_instruction_executor (
   input logic       clock,
   input logic       reset,
   tie_req_if.sink   req,
   tie_rsp_if.source rsp
);
   logic [15:0] op_ff;
   logic        busy_ff;
   logic [31:0] pc_ff;
   logic [3:0]  flags_ff;
   logic [1:0]  exc_ff;
   logic        halted_ff, arm_ff;
   logic        rv_ff;
   tie_pkg::rsp_type r_ff;

   logic [3:0]  addr_a, addr_b;
   logic [31:0] da, db, ra, rb, mul_a, mul_b, mul_p;
   logic [1:0]  exc_in;
   logic        halted_in, arm_in, fire, acc;
   tie_pkg::rsp_type res;

   // read address decode straight from the incoming item
   always_comb begin
      logic [15:0] i;
      i = req.instruction;
      addr_a = {1'b0, i[2:0]};
      addr_b = {1'b0, i[5:3]};
      case (i[15:11])
         tie_pkg::FMT_ADDSUB: addr_a = {1'b0, i[8:6]};
         tie_pkg::FMT_CMPI, tie_pkg::FMT_ADDI, tie_pkg::FMT_SUBI:
            addr_a = {1'b0, i[10:8]};
         tie_pkg::FMT_DP: if (i[10]) begin
                             addr_a = {i[7], i[2:0]};
                             addr_b = i[6:3];
                          end
         tie_pkg::FMT_ADDSP, tie_pkg::FMT_MISC0, tie_pkg::FMT_MISC1:
            addr_a = tie_pkg::REG_SP;
         default: addr_a = {1'b0, i[2:0]};
      endcase
   end

   // r15 operands read as pc + 4
   always_comb begin
      ra = da; rb = db;
      if (op_ff[15:11] == tie_pkg::FMT_DP && op_ff[10]) begin
         if ({op_ff[7], op_ff[2:0]} == tie_pkg::REG_PC) ra = pc_ff + 32'd4;
         if (op_ff[6:3] == tie_pkg::REG_PC) rb = pc_ff + 32'd4;
      end
   end

   assign mul_p = 32'(mul_a * mul_b);

   tie_regfile u_rf (
      .clock(clock), .reset(reset), .rd_en(acc),
      .rd_addr_a(addr_a), .rd_addr_b(addr_b),
      .rd_data_a(da), .rd_data_b(db),
      .wr_en(fire && res.dest_written && res.dest_index != tie_pkg::REG_PC),
      .wr_addr(res.dest_index), .wr_data(res.dest_value)
   );

   tie_execute u_ex (
      .op(op_ff), .ra(ra), .rb(rb), .pc(pc_ff), .flags(flags_ff), .exc(exc_ff),
      .halted(halted_ff), .arm(arm_ff), .res(res), .exc_in(exc_in),
      .halted_in(halted_in), .arm_in(arm_in),
      .mul_a(mul_a), .mul_b(mul_b), .mul_p(mul_p)
   );

   // execute fires when the result slot is free or being emptied
   assign fire = busy_ff && (!rv_ff || rsp.ready);
   assign acc  = req.valid && req.ready;
   assign req.ready = !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; rv_ff <= 1'b0; pc_ff <= '0; flags_ff <= '0;
         exc_ff <= tie_pkg::EXC_NONE; halted_ff <= 1'b0; arm_ff <= 1'b0;
      end else begin
         if (acc) busy_ff <= 1'b1;
         else if (fire) busy_ff <= 1'b0;
         if (fire) begin
            rv_ff <= 1'b1;
            pc_ff <= res.next_pc; flags_ff <= res.flags_out;
            exc_ff <= exc_in; halted_ff <= halted_in; arm_ff <= arm_in;
         end else if (rsp.ready) rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) op_ff <= req.instruction;
      if (fire) r_ff <= res;
   end

   assign rsp.valid        = rv_ff;
   assign rsp.next_pc      = r_ff.next_pc;
   assign rsp.dest_written = r_ff.dest_written;
   assign rsp.dest_index   = r_ff.dest_index;
   assign rsp.dest_value   = r_ff.dest_value;
   assign rsp.flags_out    = r_ff.flags_out;
   assign rsp.status       = r_ff.status;
endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Thumb instruction executor. A queue of
// instructions feeds a clocked driver; each accepted item is run through a
// behavioural model of the core, and every result is checked against the
// oldest prediction. Stop states (undefined, SWI, breakpoint, ARM state)
// latch until reset, so one of them is entered only at the end of the run.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset;

   tie_req_if req_ch ();
   tie_rsp_if rsp_ch ();

   thumb_instruction_executor dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model
   logic [31:0] gpr [16];
   logic [31:0] cur_pc;
   logic [3:0]  nzcv;
   logic [1:0]  exc_pend;
   logic        stopped, in_arm;
   logic [31:0] r_npc, r_dv;
   logic        r_wr;
   logic [3:0]  r_di;
   logic [2:0]  r_st;

   function automatic void set_nz(logic [31:0] r);
      nzcv[3] = r[31];
      nzcv[2] = (r == 32'd0);
   endfunction

   function automatic logic [31:0] add_flags(logic [31:0] a, logic [31:0] b, logic cin);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
      set_nz(s[31:0]);
      nzcv[1] = s[32];
      nzcv[0] = (a[31] ^ s[31]) & (b[31] ^ s[31]);
      return s[31:0];
   endfunction

   function automatic logic [31:0] sub_flags(logic [31:0] a, logic [31:0] b, logic cin);
      return add_flags(a, ~b, cin);
   endfunction

   function automatic logic [31:0] get_reg(logic [3:0] i);
      return (i == tie_pkg::REG_PC) ? cur_pc + 32'd4 : gpr[i];
   endfunction

   function automatic void put_reg(logic [3:0] i, logic [31:0] v);
      if (i == tie_pkg::REG_PC) begin
         v[0] = 1'b0;
         r_npc = v;
      end else begin
         gpr[i] = v;
      end
      r_wr = 1'b1;
      r_di = i;
      r_dv = v;
   endfunction

   function automatic logic [31:0] shift_l(logic [31:0] x, logic [7:0] s);
      if (s == 0) return x;
      if (s < 32) begin
         nzcv[1] = x[5'd0 - s[4:0]];
         return x << s;
      end
      nzcv[1] = (s == 32) ? x[0] : 1'b0;
      return 32'd0;
   endfunction

   function automatic logic [31:0] shift_r(logic [31:0] x, logic [7:0] s);
      if (s == 0) return x;
      if (s < 32) begin
         nzcv[1] = x[s[4:0] - 5'd1];
         return x >> s;
      end
      nzcv[1] = (s == 32) ? x[31] : 1'b0;
      return 32'd0;
   endfunction

   function automatic logic [31:0] shift_a(logic [31:0] x, logic [7:0] s);
      if (s == 0) return x;
      if (s < 32) begin
         nzcv[1] = x[s[4:0] - 5'd1];
         return $unsigned($signed(x) >>> s);
      end
      nzcv[1] = x[31];
      return {32{x[31]}};
   endfunction

   function automatic logic [31:0] rotate_r(logic [31:0] x, logic [7:0] s);
      logic [4:0]  t;
      logic [31:0] r;
      t = s[4:0];
      if (s == 0) return x;
      if (t == 0) begin
         nzcv[1] = x[31];
         return x;
      end
      r = (x >> t) | (x << (32 - t));
      nzcv[1] = r[31];
      return r;
   endfunction

   function automatic logic cond_pass(logic [3:0] cc);
      logic n, z, c, v;
      {n, z, c, v} = nzcv;
      case (cc)
         4'd0:  return z;
         4'd1:  return !z;
         4'd2:  return c;
         4'd3:  return !c;
         4'd4:  return n;
         4'd5:  return !n;
         4'd6:  return v;
         4'd7:  return !v;
         4'd8:  return c && !z;
         4'd9:  return !c || z;
         4'd10: return n == v;
         4'd11: return n != v;
         4'd12: return !z && n == v;
         default: return z || n != v;
      endcase
   endfunction

   function automatic void raise_undef();
      exc_pend = tie_pkg::EXC_UNDEF;
      r_st = tie_pkg::ST_UNDEF;
   endfunction

   function automatic void exec_alu(logic [15:0] op);
      logic [3:0]  d;
      logic [31:0] a, b, r;
      d = {1'b0, op[2:0]};
      a = gpr[d];
      b = gpr[op[5:3]];
      case (op[9:6])
         tie_pkg::ALU_AND: begin r = a & b; set_nz(r); put_reg(d, r); end
         tie_pkg::ALU_EOR: begin r = a ^ b; set_nz(r); put_reg(d, r); end
         tie_pkg::ALU_LSL: begin r = shift_l(a, b[7:0]); set_nz(r); put_reg(d, r); end
         tie_pkg::ALU_LSR: begin r = shift_r(a, b[7:0]); set_nz(r); put_reg(d, r); end
         tie_pkg::ALU_ASR: begin r = shift_a(a, b[7:0]); set_nz(r); put_reg(d, r); end
         tie_pkg::ALU_ADC: put_reg(d, add_flags(a, b, nzcv[1]));
         tie_pkg::ALU_SBC: put_reg(d, sub_flags(a, b, nzcv[1]));
         tie_pkg::ALU_ROR: begin r = rotate_r(a, b[7:0]); set_nz(r); put_reg(d, r); end
         tie_pkg::ALU_TST: set_nz(a & b);
         tie_pkg::ALU_NEG: put_reg(d, sub_flags(32'd0, b, 1'b1));
         tie_pkg::ALU_CMP: r = sub_flags(a, b, 1'b1);
         tie_pkg::ALU_CMN: r = add_flags(a, b, 1'b0);
         tie_pkg::ALU_ORR: begin r = a | b; set_nz(r); put_reg(d, r); end
         tie_pkg::ALU_MUL: begin r = a * b; set_nz(r); put_reg(d, r); end
         tie_pkg::ALU_BIC: begin r = a & ~b; set_nz(r); put_reg(d, r); end
         default: begin r = ~b; set_nz(r); put_reg(d, r); end
      endcase
   endfunction

   function automatic void exec_hireg(logic [15:0] op);
      logic [3:0]  rd, rm;
      logic [31:0] t;
      rd = {op[7], op[2:0]};
      rm = op[6:3];
      if (op[9:8] == tie_pkg::HI_BX) begin
         if (op[7]) begin
            r_st = tie_pkg::ST_UNSUP;
         end else begin
            t = get_reg(rm);
            r_npc = {t[31:1], 1'b0};
            if (!t[0]) begin
               in_arm = 1'b1;
               r_st = tie_pkg::ST_ARM;
            end
         end
      end else if (op[7:6] == 2'b00) begin
         raise_undef();
      end else if (op[9:8] == tie_pkg::HI_ADD) begin
         put_reg(rd, get_reg(rd) + get_reg(rm));
      end else if (op[9:8] == tie_pkg::HI_CMP) begin
         t = sub_flags(get_reg(rd), get_reg(rm), 1'b1);
      end else begin
         put_reg(rd, get_reg(rm));
      end
   endfunction

   function automatic void exec_misc(logic [15:0] op);
      logic [6:0]  k;
      logic [3:0]  d;
      logic [31:0] x, imm;
      k = op[11:5];
      d = {1'b0, op[2:0]};
      x = gpr[op[5:3]];
      imm = {23'd0, op[6:0], 2'b00};
      if (k <= 7'h03) put_reg(tie_pkg::REG_SP, gpr[tie_pkg::REG_SP] + imm);
      else if (k <= 7'h07) put_reg(tie_pkg::REG_SP, gpr[tie_pkg::REG_SP] - imm);
      else if (k[6:1] == 6'h08) put_reg(d, {{16{x[15]}}, x[15:0]});
      else if (k[6:1] == 6'h09) put_reg(d, {{24{x[7]}}, x[7:0]});
      else if (k[6:1] == 6'h0A) put_reg(d, {16'd0, x[15:0]});
      else if (k[6:1] == 6'h0B) put_reg(d, {24'd0, x[7:0]});
      else if (k[6:1] == 6'h28) put_reg(d, {x[7:0], x[15:8], x[23:16], x[31:24]});
      else if (k[6:1] == 6'h29) put_reg(d, {x[23:16], x[31:24], x[7:0], x[15:8]});
      else if (k[6:1] == 6'h2B) put_reg(d, {{16{x[7]}}, x[7:0], x[15:8]});
      else if ((k >= 7'h20 && k <= 7'h2F) || k == 7'h33 || (k >= 7'h60 && k <= 7'h6F)
               || k >= 7'h78)
         r_st = tie_pkg::ST_UNSUP;
      else if (k >= 7'h70) begin
         stopped = 1'b1;
         r_st = tie_pkg::ST_BKPT;
      end else raise_undef();
   endfunction

   // advance the model by one instruction and return the result it gives
   function automatic tie_pkg::rsp_type exec_thumb(logic [15:0] op);
      logic [31:0]      pcv, t;
      logic [3:0]       d8;
      tie_pkg::rsp_type res;
      pcv = cur_pc + 32'd4;
      d8 = {1'b0, op[10:8]};
      r_wr = 1'b0;
      r_di = 4'd0;
      r_dv = 32'd0;
      r_st = tie_pkg::ST_OK;
      r_npc = cur_pc;
      if (stopped) r_st = tie_pkg::ST_HALTED;
      else if (in_arm) r_st = tie_pkg::ST_ARM;
      else if (exc_pend != tie_pkg::EXC_NONE) begin
         stopped = 1'b1;
         r_st = tie_pkg::ST_HALTED;
      end else begin
         r_npc = cur_pc + 32'd2;
         case (op[15:11])
            tie_pkg::FMT_LSL: begin
               t = shift_l(gpr[op[5:3]], {3'd0, op[10:6]});
               set_nz(t);
               put_reg({1'b0, op[2:0]}, t);
            end
            tie_pkg::FMT_LSR, tie_pkg::FMT_ASR: begin
               t = (op[15:11] == tie_pkg::FMT_LSR)
                   ? shift_r(gpr[op[5:3]], (op[10:6] == 0) ? 8'd32 : {3'd0, op[10:6]})
                   : shift_a(gpr[op[5:3]], (op[10:6] == 0) ? 8'd32 : {3'd0, op[10:6]});
               set_nz(t);
               put_reg({1'b0, op[2:0]}, t);
            end
            tie_pkg::FMT_ADDSUB: begin
               t = op[10] ? {29'd0, op[8:6]} : gpr[op[8:6]];
               put_reg({1'b0, op[2:0]}, op[9] ? sub_flags(gpr[op[5:3]], t, 1'b1)
                                              : add_flags(gpr[op[5:3]], t, 1'b0));
            end
            tie_pkg::FMT_MOVI: begin
               set_nz({24'd0, op[7:0]});
               put_reg(d8, {24'd0, op[7:0]});
            end
            tie_pkg::FMT_CMPI: t = sub_flags(gpr[d8], {24'd0, op[7:0]}, 1'b1);
            tie_pkg::FMT_ADDI: put_reg(d8, add_flags(gpr[d8], {24'd0, op[7:0]}, 1'b0));
            tie_pkg::FMT_SUBI: put_reg(d8, sub_flags(gpr[d8], {24'd0, op[7:0]}, 1'b1));
            tie_pkg::FMT_DP: if (op[10]) exec_hireg(op); else exec_alu(op);
            tie_pkg::FMT_ADR: put_reg(d8, {pcv[31:2], 2'b00} + {22'd0, op[7:0], 2'b00});
            tie_pkg::FMT_ADDSP:
               put_reg(d8, gpr[tie_pkg::REG_SP] + {22'd0, op[7:0], 2'b00});
            tie_pkg::FMT_MISC0, tie_pkg::FMT_MISC1: exec_misc(op);
            tie_pkg::FMT_BCC0, tie_pkg::FMT_BCC1: begin
               if (op[11:8] == tie_pkg::COND_UNDEF) raise_undef();
               else if (op[11:8] == tie_pkg::COND_SWI) begin
                  exc_pend = tie_pkg::EXC_SWI;
                  r_st = tie_pkg::ST_SWI;
               end else if (cond_pass(op[11:8]))
                  r_npc = pcv + {{23{op[7]}}, op[7:0], 1'b0};
            end
            tie_pkg::FMT_B: r_npc = pcv + {{20{op[10]}}, op[10:0], 1'b0};
            default: r_st = tie_pkg::ST_UNSUP;
         endcase
         cur_pc = r_npc;
      end
      res.next_pc = r_npc;
      res.dest_written = r_wr;
      res.dest_index = r_di;
      res.dest_value = r_dv;
      res.flags_out = nzcv;
      res.status = r_st;
      return res;
   endfunction

   // true for encodings that can stop the core for the rest of the run
   function automatic logic stops_core(logic [15:0] op);
      logic [6:0] k;
      k = op[11:5];
      case (op[15:11])
         tie_pkg::FMT_BCC0, tie_pkg::FMT_BCC1: return op[11:9] == 3'b111;
         tie_pkg::FMT_DP:
            return op[10] && (op[9:8] == tie_pkg::HI_BX ? !op[7] : op[7:6] == 2'b00);
         tie_pkg::FMT_MISC0, tie_pkg::FMT_MISC1:
            return (k >= 7'h08 && k <= 7'h0F) || (k >= 7'h18 && k <= 7'h1F)
                || (k >= 7'h30 && k <= 7'h32) || (k >= 7'h34 && k <= 7'h4F)
                || k == 7'h54 || k == 7'h55 || (k >= 7'h58 && k <= 7'h5F)
                || (k >= 7'h70 && k <= 7'h77);
         default: return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------- bench
   logic [15:0]      instr_q [$];
   tie_pkg::rsp_type expect_q [$];
   int               n_acc = 0;
   int               n_err = 0;
   int               idle_cnt = 0;
   logic             took = 1'b0;
   logic             quiet;

   assign quiet = (n_acc >= 700) && (n_acc < 1000);

   function automatic logic [15:0] safe_instr();
      logic [15:0] op;
      do begin
         op = 16'($urandom());
         if ($urandom_range(0, 99) < 30) op[15:10] = 6'b010000;
      end while (stops_core(op));
      return op;
   endfunction

   // driver: present an item, hold it until taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!(req_ch.valid && !took)) begin
            if (instr_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 37)) begin
               req_ch.valid <= 1'b1;
               req_ch.instruction <= instr_q[0];
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 37);
      end
   end

   // monitor: predict on each accepted item, check each accepted result
   always @(posedge clock) begin
      tie_pkg::rsp_type got, want;
      if (!reset) begin
         took = req_ch.valid && req_ch.ready;
         idle_cnt = idle_cnt + 1;
         if (took) begin
            expect_q.push_back(exec_thumb(req_ch.instruction));
            void'(instr_q.pop_front());
            n_acc = n_acc + 1;
            idle_cnt = 0;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            idle_cnt = 0;
            got.next_pc = rsp_ch.next_pc;
            got.dest_written = rsp_ch.dest_written;
            got.dest_index = rsp_ch.dest_index;
            got.dest_value = rsp_ch.dest_value;
            got.flags_out = rsp_ch.flags_out;
            got.status = rsp_ch.status;
            if (expect_q.size() == 0) begin
               $display("%0t: unexpected result pc=%h st=%0d", $time, got.next_pc, got.status);
               n_err = n_err + 1;
            end else begin
               want = expect_q.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch exp pc=%h wr=%b idx=%0d val=%h nzcv=%b st=%0d",
                           $time, want.next_pc, want.dest_written, want.dest_index,
                           want.dest_value, want.flags_out, want.status);
                  $display("%0t:          got pc=%h wr=%b idx=%0d val=%h nzcv=%b st=%0d",
                           $time, got.next_pc, got.dest_written, got.dest_index,
                           got.dest_value, got.flags_out, got.status);
                  n_err = n_err + 1;
               end
            end
         end
         if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no item moved for %0d cycles", $time, idle_cnt);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      logic [15:0] op;
      logic [2:0]  rd;
      int          i;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.instruction = 16'd0;
      rsp_ch.ready = 1'b0;
      gpr = '{default: 32'd0};
      cur_pc = 32'd0;
      nzcv = 4'd0;
      exc_pend = tie_pkg::EXC_NONE;
      stopped = 1'b0;
      in_arm = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, every ALU op, high regs, misc, branches
      instr_q.push_back(16'h20FF);   // movs r0,#255
      instr_q.push_back(16'h07C0);   // lsls r0,r0,#31
      instr_q.push_back(16'h0801);   // lsrs r1,r0,#32
      instr_q.push_back(16'h1002);   // asrs r2,r0,#32
      instr_q.push_back(16'h1E56);   // subs r6,r2,#1
      instr_q.push_back(16'h39FF);   // subs r1,#255
      for (i = 0; i < 16; i++)
         instr_q.push_back({6'b010000, 4'(i), 3'(i + 1), 3'(i)});
      instr_q.push_back(16'h44E8);   // add r8,sp
      instr_q.push_back(16'h46F7);   // mov pc,lr
      instr_q.push_back(16'hA0FF);   // adr r0
      instr_q.push_back(16'hB07F);   // add sp,#508
      instr_q.push_back(16'hB2C1);   // uxtb
      instr_q.push_back(16'hBA0A);   // rev
      instr_q.push_back(16'hD0FE);   // beq back
      instr_q.push_back(16'hE400);   // b, negative offset
      instr_q.push_back(16'hFFFF);   // unsupported prefix
      instr_q.push_back(16'h2001);   // movs r0,#1
      instr_q.push_back(16'h4700);   // bx r0, stays in thumb

      // hold the sender until every result is back
      wait (instr_q.size() == 0 && expect_q.size() == 0);

      // random run: mostly live instructions, with odd-target BX pairs
      i = 0;
      while (i < 1750) begin
         if ($urandom_range(0, 99) < 5) begin
            rd = 3'($urandom());
            instr_q.push_back({5'b00100, rd, 7'($urandom()), 1'b1});
            instr_q.push_back({9'b010001110, 1'b0, rd, 3'b000});
            i = i + 2;
         end else begin
            instr_q.push_back(safe_instr());
            i = i + 1;
         end
      end

      // one stopping event, then items that must all report the stop
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 2))
               0: op = {8'hDE, 8'($urandom())};
               1: op = {8'h44, 2'b00, 6'($urandom())};
               default: op = 16'hB100;
            endcase
            instr_q.push_back(op);
         end
         1: instr_q.push_back({8'hDF, 8'($urandom())});
         2: instr_q.push_back({8'hBE, 8'($urandom())});
         default: begin
            instr_q.push_back({5'b00100, 3'd3, 7'($urandom()), 1'b0});
            instr_q.push_back(16'h4718);   // bx r3, even target
         end
      endcase
      for (i = 0; i < 8; i++) instr_q.push_back(16'($urandom()));

      wait (instr_q.size() == 0 && expect_q.size() == 0);
      repeat (8) @(posedge clock);
      if (n_err == 0 && expect_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
